// ===== hdl/imm_pkg.sv =====
// shared types and constants for the integer matrix multiplier
// no dependencies; imported by every module of the block
package imm_pkg;

  // largest supported matrix dimension
  localparam int MAX_DIM = 8;
  localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W  = 2 * DIM_W;
  localparam int DEPTH   = 2 ** ADDR_W;

  // fixed field widths
  localparam int IDX_W  = 3;
  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = 35;
  localparam int CFG_W  = 4;
  localparam int REG_W  = 2;

  // item modes
  typedef enum logic [1:0] {
    MODE_LOAD_A  = 2'd0,
    MODE_LOAD_B  = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_t;

  // configuration register indexes
  localparam logic [REG_W-1:0] REG_NUM_ROWS  = 2'd0;
  localparam logic [REG_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [REG_W-1:0] REG_NUM_COLS  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic              rd_en;
    logic              first;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic              emit;
    logic [DIM_W-1:0]  row;
    logic [DIM_W-1:0]  col;
    logic              last;
  } imm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic busy;
    logic out_free;
  } imm_sts_t;

endpackage

// ===== hdl/integer_matrix_multiplier.sv =====
// top level of the integer matrix multiplier
// depends on imm_pkg, imm_ctrl and imm_datapath
//
// Load items (mode 0 for A, 1 for B) write one signed 16-bit element. A
// compute item (mode 2) stalls the item port until the whole product has
// been handed to the result register: each product element takes
// inner_dim reads of the two element stores, then the registered read,
// multiply and accumulate stages drain, and any stall on the result side
// holds it further. Results come out in row-major order with last_flag on
// the final element. Dimension registers of 0 act as 1, above 8 act as 8.
module integer_matrix_multiplier (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_en,
  input  logic [imm_pkg::REG_W-1:0]         reg_index,
  input  logic [imm_pkg::CFG_W-1:0]         write_data,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [1:0]                        mode,
  input  logic [imm_pkg::IDX_W-1:0]         row_index,
  input  logic [imm_pkg::IDX_W-1:0]         col_index,
  input  logic signed [imm_pkg::ELEM_W-1:0] element_value,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [imm_pkg::IDX_W-1:0]         result_row,
  output logic [imm_pkg::IDX_W-1:0]         result_col,
  output logic signed [imm_pkg::ACC_W-1:0]  product_value,
  output logic                              last_flag
);
  import imm_pkg::*;

  imm_cmd_t cmd;
  imm_sts_t sts;

  // sequencing and configuration
  imm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .write_en   (write_en),
    .reg_index  (reg_index),
    .write_data (write_data),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .mode       (mode),
    .cmd        (cmd),
    .sts        (sts)
  );

  // storage and arithmetic
  imm_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .row_index     (row_index),
    .col_index     (col_index),
    .element_value (element_value),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result_row    (result_row),
    .result_col    (result_col),
    .product_value (product_value),
    .last_flag     (last_flag)
  );

endmodule

// ===== hdl/imm_datapath.sv =====
// datapath: element stores for A and B, multiply-accumulate pipeline, result register
// depends on imm_pkg
module imm_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  imm_pkg::imm_cmd_t            cmd,
  output imm_pkg::imm_sts_t            sts,
  input  logic [imm_pkg::IDX_W-1:0]    row_index,
  input  logic [imm_pkg::IDX_W-1:0]    col_index,
  input  logic signed [imm_pkg::ELEM_W-1:0] element_value,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [imm_pkg::IDX_W-1:0]    result_row,
  output logic [imm_pkg::IDX_W-1:0]    result_col,
  output logic signed [imm_pkg::ACC_W-1:0] product_value,
  output logic                         last_flag
);
  import imm_pkg::*;

  logic signed [ELEM_W-1:0] mem_a [DEPTH];
  logic signed [ELEM_W-1:0] mem_b [DEPTH];
  logic signed [ELEM_W-1:0] a_q;
  logic signed [ELEM_W-1:0] b_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     rd_v;
  logic                     rd_first;
  logic                     mac_v;
  logic                     mac_first;
  logic                     idx_ok;
  logic [ADDR_W-1:0]        wr_addr;

  // load address, out-of-range indexes are dropped
  always_comb begin
    idx_ok  = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
    wr_addr = {row_index[DIM_W-1:0], col_index[DIM_W-1:0]};
  end

  // element stores, one write and one registered read each
  always_ff @(posedge clk) begin
    if (cmd.wr_a && idx_ok) begin
      mem_a[wr_addr] <= element_value;
    end
    if (cmd.wr_b && idx_ok) begin
      mem_b[wr_addr] <= element_value;
    end
    if (cmd.rd_en) begin
      a_q <= mem_a[cmd.a_addr];
      b_q <= mem_b[cmd.b_addr];
    end
  end

  // multiply then accumulate, one stage each
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      mac_v <= 1'b0;
    end else begin
      rd_v  <= cmd.rd_en;
      mac_v <= rd_v;
    end
    rd_first  <= cmd.first;
    mac_first <= rd_first;
    if (rd_v) begin
      prod <= a_q * b_q;
    end
    if (mac_v) begin
      acc <= mac_first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  // result register, freed by a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (cmd.emit) begin
      result_row    <= IDX_W'(cmd.row);
      result_col    <= IDX_W'(cmd.col);
      product_value <= acc;
      last_flag     <= cmd.last;
    end
  end

  // status back to the controller
  always_comb begin
    sts.busy     = rd_v | mac_v;
    sts.out_free = !result_valid || !result_stall;
  end

endmodule

// ===== hdl/imm_ctrl.sv =====
// controller: configuration registers, item handshake and the row/column/inner walk
// depends on imm_pkg
module imm_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      write_en,
  input  logic [imm_pkg::REG_W-1:0] reg_index,
  input  logic [imm_pkg::CFG_W-1:0] write_data,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic [1:0]                mode,
  output imm_pkg::imm_cmd_t         cmd,
  input  imm_pkg::imm_sts_t         sts
);
  import imm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  state_t             state;
  logic [CFG_W-1:0]   num_rows;
  logic [CFG_W-1:0]   inner_dim;
  logic [CFG_W-1:0]   num_cols;
  logic [DIM_W-1:0]   row_last;
  logic [DIM_W-1:0]   inner_last;
  logic [DIM_W-1:0]   col_last;
  logic [DIM_W-1:0]   i;
  logic [DIM_W-1:0]   j;
  logic [DIM_W-1:0]   k;
  logic               accept;

  // clamp a dimension register into 1..MAX_DIM and return it minus one
  function automatic logic [DIM_W-1:0] dim_last(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM - 1);
    end else begin
      r = DIM_W'(v - 1'b1);
    end
    return r;
  endfunction

  // handshake and commands
  always_comb begin
    item_stall = (state != ST_IDLE);
    accept     = item_valid && !item_stall;
    cmd.wr_a   = accept && (mode == MODE_LOAD_A);
    cmd.wr_b   = accept && (mode == MODE_LOAD_B);
    cmd.rd_en  = (state == ST_ISSUE);
    cmd.first  = (k == '0);
    cmd.a_addr = {i, k};
    cmd.b_addr = {k, j};
    cmd.emit   = (state == ST_DRAIN) && !sts.busy && sts.out_free;
    cmd.row    = i;
    cmd.col    = j;
    cmd.last   = (i == row_last) && (j == col_last);
  end

  // state, counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      num_rows  <= CFG_W'(MAX_DIM);
      inner_dim <= CFG_W'(MAX_DIM);
      num_cols  <= CFG_W'(MAX_DIM);
      i         <= '0;
      j         <= '0;
      k         <= '0;
    end else begin
      if (write_en) begin
        case (reg_index)
          REG_NUM_ROWS:  num_rows  <= write_data;
          REG_INNER_DIM: inner_dim <= write_data;
          REG_NUM_COLS:  num_cols  <= write_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept && (mode == MODE_COMPUTE)) begin
            row_last   <= dim_last(num_rows);
            inner_last <= dim_last(inner_dim);
            col_last   <= dim_last(num_cols);
            i          <= '0;
            j          <= '0;
            k          <= '0;
            state      <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (k == inner_last) begin
            state <= ST_DRAIN;
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (cmd.emit) begin
            k <= '0;
            if (j == col_last) begin
              j <= '0;
              if (i == row_last) begin
                state <= ST_IDLE;
              end else begin
                i     <= i + 1'b1;
                state <= ST_ISSUE;
              end
            end else begin
              j     <= j + 1'b1;
              state <= ST_ISSUE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result is latched only once the accumulator has settled and the slot is free
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!sts.busy && sts.out_free))
    else $error("result latched while accumulation in flight");

  // loads never overlap a multiply-accumulate run
  assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_a || cmd.wr_b) |-> !sts.busy)
    else $error("load during accumulation");

  // the final element of a run returns the controller to idle
  assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> (state == ST_IDLE))
    else $error("run did not end after last element");
`endif

endmodule
